### src/mcm_pkg.sv
// Shared types and constants for the matrix-chain cost block.
`timescale 1ns / 1ps

package mcm_pkg;

	localparam int DIM_W   = 16;
	localparam int COST_W  = 63;
	localparam int PROD1_W = 2 * DIM_W;
	localparam int PROD_W  = 3 * DIM_W;

	localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FEW  = 2'd1;
	localparam logic [1:0] ST_MANY = 2'd2;

	typedef enum logic [1:0] {
		S_LOAD,
		S_ENTRY,
		S_STEP,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic       dim_we;
		logic       ent_rd;
		logic       step;
		logic       left_zero;
		logic       right_zero;
		logic       best_init;
		logic       best_wr;
		logic       out_stat;
		logic       out_best;
		logic [1:0] status;
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} stat_t;

endpackage

### src/mcm_intf.sv
// Valid/ready channel interfaces for dimension input and cost output.
`timescale 1ns / 1ps

interface mcm_in_if;
	logic                     valid;
	logic                     ready;
	logic [mcm_pkg::DIM_W-1:0] dim;
	logic                     last;

	modport source (output valid, output dim, output last, input ready);
	modport sink (input valid, input dim, input last, output ready);
endinterface

interface mcm_out_if;
	logic                      valid;
	logic                      ready;
	logic [mcm_pkg::COST_W-1:0] total_cost;
	logic [1:0]                status;

	modport source (output valid, output total_cost, output status, input ready);
	modport sink (input valid, input total_cost, input status, output ready);
endinterface

### src/matrix_chain_min_cost.sv
// Matrix-chain minimum cost. Dimensions are taken only while loading with the output free.
// After the last of n+1 dimensions the fill goes entry by entry, bound by the one split pipeline.
// Short, overlong and single-matrix chains answer the cycle after the last transaction.
// One chain at a time; arst_n clears control state and empties the output; stores need no init.
`timescale 1ns / 1ps

module matrix_chain_min_cost #(
	parameter int MAX_MATRICES = 16,
	parameter int DIM_BITS     = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	mcm_in_if.sink   in_ch,
	mcm_out_if.source out_ch
);

	localparam int DW = $clog2(MAX_MATRICES + 1);
	localparam int IW = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;

	mcm_pkg::cmd_t  cmd;
	mcm_pkg::stat_t stat;
	logic [DW-1:0]  dim_waddr;
	logic [IW-1:0]  idx_i;
	logic [IW-1:0]  idx_j;
	logic [IW-1:0]  idx_k;

	mcm_ctrl #(
		.MAX_MATRICES(MAX_MATRICES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last),
		.in_ready  (in_ch.ready),
		.stat      (stat),
		.cmd       (cmd),
		.dim_waddr (dim_waddr),
		.idx_i     (idx_i),
		.idx_j     (idx_j),
		.idx_k     (idx_k)
	);

	mcm_dp #(
		.MAX_MATRICES(MAX_MATRICES),
		.DIM_BITS    (DIM_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.dim_in         (in_ch.dim),
		.dim_waddr      (dim_waddr),
		.idx_i          (idx_i),
		.idx_j          (idx_j),
		.idx_k          (idx_k),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.out_total_cost (out_ch.total_cost),
		.out_status     (out_ch.status)
	);

`ifndef ASSERT_OFF
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && !in_ch.last && !out_ch.valid) |=> !out_ch.valid)
		else $error("result produced by a transaction without last");

	a_err_zero_cost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status != mcm_pkg::ST_OK) |-> (out_ch.total_cost == '0))
		else $error("error status with nonzero cost");

	a_write_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.best_wr |-> !stat.pipe_busy)
		else $error("cost entry written while split pipeline busy");

	a_dim_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dim_we |-> (in_ch.valid && in_ch.ready))
		else $error("dimension store written without input transaction");
`endif

endmodule

### src/mcm_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module mcm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic [WIDTH-1:0]                      rdata_a,
	output logic [WIDTH-1:0]                      rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### src/mcm_ctrl.sv
// Controller: chain loading, span/row/split sequencing and result hand-off.
`timescale 1ns / 1ps

module mcm_ctrl #(
	parameter int MAX_MATRICES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_last,
	output logic                 in_ready,
	input  mcm_pkg::stat_t       stat,
	output mcm_pkg::cmd_t        cmd,
	output logic [$clog2(MAX_MATRICES + 1)-1:0] dim_waddr,
	output logic [(MAX_MATRICES > 1 ? $clog2(MAX_MATRICES) : 1)-1:0] idx_i,
	output logic [(MAX_MATRICES > 1 ? $clog2(MAX_MATRICES) : 1)-1:0] idx_j,
	output logic [(MAX_MATRICES > 1 ? $clog2(MAX_MATRICES) : 1)-1:0] idx_k
);

	localparam int DEPTH = MAX_MATRICES + 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int DW    = $clog2(DEPTH);
	localparam int IW    = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;

	mcm_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [DW-1:0] nmat_q;
	logic [IW-1:0] span_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] k_q;

	logic          accept;
	logic          has_room;
	logic [CW-1:0] cnt_new;
	logic          ovf_now;
	logic          start_fill;
	logic [IW-1:0] j;
	logic          last_k;
	logic          final_ent;
	logic          row_more;
	logic          adv;

	always_comb begin
		accept     = in_valid && in_ready;
		has_room   = count_q < CW'(DEPTH);
		cnt_new    = has_room ? count_q + CW'(1) : count_q;
		ovf_now    = ovf_q || !has_room;
		start_fill = accept && in_last && !ovf_now && (cnt_new > CW'(2));
		j          = i_q + span_q;
		last_k     = (k_q + IW'(1)) == j;
		final_ent  = (DW'(span_q) + DW'(1)) == nmat_q;
		row_more   = (DW'(j) + DW'(1)) < nmat_q;
		// entry is written once the split pipeline is empty; the last one also needs the output
		adv        = !stat.pipe_busy && (!final_ent || stat.out_free);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mcm_pkg::S_LOAD: begin
				if (start_fill) begin
					state_d = mcm_pkg::S_ENTRY;
				end
			end
			mcm_pkg::S_ENTRY: begin
				state_d = mcm_pkg::S_STEP;
			end
			mcm_pkg::S_STEP: begin
				if (last_k) begin
					state_d = mcm_pkg::S_DRAIN;
				end
			end
			mcm_pkg::S_DRAIN: begin
				if (adv) begin
					state_d = final_ent ? mcm_pkg::S_LOAD : mcm_pkg::S_ENTRY;
				end
			end
			default: begin
				state_d = mcm_pkg::S_LOAD;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			mcm_pkg::S_LOAD: begin
				in_ready     = stat.out_free;
				cmd.dim_we   = accept && has_room;
				cmd.out_stat = accept && in_last && (ovf_now || cnt_new <= CW'(2));
				if (ovf_now) begin
					cmd.status = mcm_pkg::ST_MANY;
				end else if (cnt_new < CW'(2)) begin
					cmd.status = mcm_pkg::ST_FEW;
				end else begin
					cmd.status = mcm_pkg::ST_OK;
				end
			end
			mcm_pkg::S_ENTRY: begin
				cmd.ent_rd    = 1'b1;
				cmd.best_init = 1'b1;
			end
			mcm_pkg::S_STEP: begin
				cmd.step       = 1'b1;
				cmd.left_zero  = k_q == i_q;
				cmd.right_zero = last_k;
			end
			mcm_pkg::S_DRAIN: begin
				cmd.best_wr  = adv;
				cmd.out_best = adv && final_ent;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcm_pkg::S_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			nmat_q  <= '0;
			span_q  <= '0;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				mcm_pkg::S_LOAD: begin
					if (accept) begin
						if (in_last) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else if (has_room) begin
							count_q <= cnt_new;
						end else begin
							ovf_q <= 1'b1;
						end
						if (start_fill) begin
							nmat_q <= DW'(cnt_new - CW'(1));
							span_q <= IW'(1);
							i_q    <= '0;
						end
					end
				end
				mcm_pkg::S_ENTRY: begin
					k_q <= i_q;
				end
				mcm_pkg::S_STEP: begin
					if (!last_k) begin
						k_q <= k_q + IW'(1);
					end
				end
				mcm_pkg::S_DRAIN: begin
					if (adv && !final_ent) begin
						if (row_more) begin
							i_q <= i_q + IW'(1);
						end else begin
							span_q <= span_q + IW'(1);
							i_q    <= '0;
						end
					end
				end
				default: begin
					count_q <= '0;
				end
			endcase
		end
	end

	assign dim_waddr = count_q[DW-1:0];
	assign idx_i     = i_q;
	assign idx_j     = j;
	assign idx_k     = k_q;

endmodule

### src/mcm_dp.sv
// Datapath: dimension and cost stores, split-cost pipeline, running minimum, output register.
`timescale 1ns / 1ps

module mcm_dp #(
	parameter int MAX_MATRICES = 16,
	parameter int DIM_BITS     = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mcm_pkg::cmd_t                     cmd,
	output mcm_pkg::stat_t                    stat,
	input  logic [mcm_pkg::DIM_W-1:0]         dim_in,
	input  logic [$clog2(MAX_MATRICES + 1)-1:0] dim_waddr,
	input  logic [(MAX_MATRICES > 1 ? $clog2(MAX_MATRICES) : 1)-1:0] idx_i,
	input  logic [(MAX_MATRICES > 1 ? $clog2(MAX_MATRICES) : 1)-1:0] idx_j,
	input  logic [(MAX_MATRICES > 1 ? $clog2(MAX_MATRICES) : 1)-1:0] idx_k,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [mcm_pkg::COST_W-1:0]        out_total_cost,
	output logic [1:0]                        out_status
);

	localparam int DEPTH  = MAX_MATRICES + 1;
	localparam int DW     = $clog2(DEPTH);
	localparam int IW     = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
	localparam int TDEPTH = 1 << (2 * IW);
	localparam int DIM_W  = mcm_pkg::DIM_W;
	localparam int COST_W = mcm_pkg::COST_W;
	localparam logic [DIM_W-1:0] DIM_MASK =
		(DIM_BITS >= DIM_W) ? {DIM_W{1'b1}} : DIM_W'((64'd1 << DIM_BITS) - 64'd1);

	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
			input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? mcm_pkg::COST_SAT : s[COST_W-1:0];
	endfunction

	logic [DW-1:0]     dim_ra;
	logic [DW-1:0]     dim_rb;
	logic [DIM_W-1:0]  dim_qa;
	logic [DIM_W-1:0]  dim_qb;
	logic [2*IW-1:0]   cost_wa;
	logic [2*IW-1:0]   cost_ra;
	logic [2*IW-1:0]   cost_rb;
	logic [COST_W-1:0] cost_qa;
	logic [COST_W-1:0] cost_qb;
	logic [COST_W-1:0] left_c;
	logic [COST_W-1:0] right_c;

	logic              ent_s1;
	logic              v_s1, v_s2, v_s3, v_s4;
	logic              lz_s1, rz_s1;
	logic [DIM_W-1:0]  di_q, dj_q;
	logic [mcm_pkg::PROD1_W-1:0] p1_s2;
	logic [COST_W-1:0] sum_s2, sum_s3;
	logic [mcm_pkg::PROD_W-1:0]  p_s3;
	logic [COST_W-1:0] c_s4;
	logic [COST_W-1:0] best_q;
	logic              out_valid_q;
	logic [COST_W-1:0] total_cost_q;
	logic [1:0]        status_q;

	// port A gives d[i] on entry start, then d[k+1] each split; port B gives d[j+1]
	assign dim_ra  = cmd.step ? DW'(idx_k) + DW'(1) : DW'(idx_i);
	assign dim_rb  = DW'(idx_j) + DW'(1);
	assign cost_wa = {idx_i, idx_j};
	assign cost_ra = {idx_i, idx_k};
	assign cost_rb = {idx_k + IW'(1), idx_j};

	mcm_ram #(
		.WIDTH(DIM_W),
		.DEPTH(DEPTH)
	) u_dim_ram (
		.clk     (clk),
		.we      (cmd.dim_we),
		.waddr   (dim_waddr),
		.wdata   (dim_in & DIM_MASK),
		.raddr_a (dim_ra),
		.raddr_b (dim_rb),
		.rdata_a (dim_qa),
		.rdata_b (dim_qb)
	);

	mcm_ram #(
		.WIDTH(COST_W),
		.DEPTH(TDEPTH)
	) u_cost_ram (
		.clk     (clk),
		.we      (cmd.best_wr),
		.waddr   (cost_wa),
		.wdata   (best_q),
		.raddr_a (cost_ra),
		.raddr_b (cost_rb),
		.rdata_a (cost_qa),
		.rdata_b (cost_qb)
	);

	// diagonal entries are zero and never stored
	assign left_c  = lz_s1 ? '0 : cost_qa;
	assign right_c = rz_s1 ? '0 : cost_qb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_s1 <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else begin
			ent_s1 <= cmd.ent_rd;
			v_s1   <= cmd.step;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		lz_s1  <= cmd.left_zero;
		rz_s1  <= cmd.right_zero;
		if (ent_s1) begin
			di_q <= dim_qa;
			dj_q <= dim_qb;
		end
		p1_s2  <= mcm_pkg::PROD1_W'(di_q) * mcm_pkg::PROD1_W'(dim_qa);
		sum_s2 <= sat_add(left_c, right_c);
		p_s3   <= mcm_pkg::PROD_W'(p1_s2) * mcm_pkg::PROD_W'(dj_q);
		sum_s3 <= sum_s2;
		c_s4   <= sat_add(sum_s3, COST_W'(p_s3));
		if (cmd.best_init) begin
			best_q <= mcm_pkg::COST_SAT;
		end else if (v_s4 && (c_s4 < best_q)) begin
			best_q <= c_s4;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_stat || cmd.out_best) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_best) begin
			total_cost_q <= best_q;
			status_q     <= mcm_pkg::ST_OK;
		end else if (cmd.out_stat) begin
			total_cost_q <= '0;
			status_q     <= cmd.status;
		end
	end

	assign stat.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign stat.out_free  = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign out_total_cost = total_cost_q;
	assign out_status     = status_q;

endmodule
